// ===== rtl/jts_pkg.sv =====
// ----------------------------------------------------------------------------
// jts_pkg
// shared types and constants of the token scanner: token kinds, scan modes,
// the per-byte queue record
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    K_COLON    = 4'd0,
    K_COMMA    = 4'd1,
    K_LBRACE   = 4'd2,
    K_RBRACE   = 4'd3,
    K_LBRACKET = 4'd4,
    K_RBRACKET = 4'd5,
    K_INTEGER  = 4'd6,
    K_STRBYTE  = 4'd7,
    K_STREND   = 4'd8,
    K_EOI      = 4'd9,
    K_BADCHAR  = 4'd10,
    K_UNTERM   = 4'd11,
    K_BADESC   = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_ZERO = 3'd1,
    M_DEC  = 3'd2,
    M_OCT  = 3'd3,
    M_HEX  = 3'd4,
    M_STR  = 3'd5,
    M_ESC  = 3'd6
  } mode_t;

  // results of one input byte; the second token never carries an integer
  typedef struct packed {
    logic        two;
    kind_t       k0;
    logic [63:0] v0;
    logic [7:0]  b0;
    kind_t       k1;
    logic [7:0]  b1;
  } rec_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } qstat_t;

endpackage

// ===== rtl/json_token_scanner_core.sv =====
// ----------------------------------------------------------------------------
// json_token_scanner_core
// throughput: one input byte per cycle while in_stall is low (queue not full);
//   a byte giving two tokens occupies the output for two transactions
// flow: the first token of a byte is written into the queue, then loaded
//   into the output register, where out_stall can hold it
// reset: synchronous rst_n clears scan mode, accumulator, queue and output
// ----------------------------------------------------------------------------
module json_token_scanner_core import jts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel: one transaction per byte or end marker
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  // result channel: one transaction per token
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [63:0] out_int_value,
  output logic [7:0]  out_string_byte,
  output logic        out_last
);

  // front scans each byte in its accepting cycle and pushes a record of up
  // to two tokens; bytes with no result (whitespace, digits) push nothing
  logic   push;
  rec_t   push_rec;
  logic   pop;
  rec_t   head_rec;
  qstat_t q_stat;

  jts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_end_of_input (in_end_of_input),
    .q_stat          (q_stat),
    .push            (push),
    .push_rec        (push_rec)
  );

  // the queue decouples scanning from output back-pressure
  jts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  // back end serialises a two-token record over two transactions
  jts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_rec        (head_rec),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_int_value   (out_int_value),
    .out_string_byte (out_string_byte),
    .out_last        (out_last)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("queue underflow");

  // occupancy stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCW'(QDEPTH))
    else $error("queue count out of range");

  // only integer tokens carry a value
  a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != K_INTEGER) |-> (out_int_value == '0))
    else $error("value on non-integer token");

endmodule

// ===== rtl/jts_front.sv =====
// ----------------------------------------------------------------------------
// jts_front
// per-byte scanner: mode and accumulator update, builds the result record
// ----------------------------------------------------------------------------
module jts_front import jts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_input,
  input  qstat_t     q_stat,
  output logic       push,
  output rec_t       push_rec
);

  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  mode_t       mode_r, mode_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic        accept;
  logic        eoi;
  logic [7:0]  ch;
  logic        is_dig, is_oct, is_89, is_hex;
  logic [3:0]  hex_val;
  logic [63:0] acc_dec, acc_oct, acc_hex;

  // token-start scan
  logic        st_emit;
  kind_t       st_kind;
  logic [7:0]  st_byte;
  mode_t       st_mode;
  logic        st_acc_ld;
  logic [63:0] st_acc;

  logic        has0;
  rec_t        rec;

  assign accept   = in_valid && !q_stat.full;
  assign in_stall = q_stat.full;
  assign eoi      = in_end_of_input;
  assign ch       = in_char_byte;

  assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_oct  = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
  assign is_89   = is_dig && !is_oct;
  assign is_hex  = is_dig || ((ch >= CH_LA) && (ch <= CH_LF_HEX)) ||
                   ((ch >= CH_UA) && (ch <= CH_UF));
  assign hex_val = is_dig ? ch[3:0] : ch[3:0] + 4'd9;

  assign acc_dec = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, ch[3:0]};
  assign acc_oct = {acc_r[60:0], ch[2:0]};
  assign acc_hex = {acc_r[59:0], hex_val};

  always_comb begin
    st_emit   = 1'b0;
    st_kind   = K_BADCHAR;
    st_byte   = '0;
    st_mode   = M_IDLE;
    st_acc_ld = 1'b0;
    st_acc    = '0;
    if (eoi) begin
      st_emit = 1'b1;
      st_kind = K_EOI;
    end else begin
      unique case (ch)
        CH_SP, CH_TAB, CH_CR, CH_LF: ;
        CH_QUOTE:  st_mode = M_STR;
        CH_COLON:  begin st_emit = 1'b1; st_kind = K_COLON;    end
        CH_COMMA:  begin st_emit = 1'b1; st_kind = K_COMMA;    end
        CH_LBRACE: begin st_emit = 1'b1; st_kind = K_LBRACE;   end
        CH_RBRACE: begin st_emit = 1'b1; st_kind = K_RBRACE;   end
        CH_LBRACK: begin st_emit = 1'b1; st_kind = K_LBRACKET; end
        CH_RBRACK: begin st_emit = 1'b1; st_kind = K_RBRACKET; end
        CH_ZERO: begin
          st_mode   = M_ZERO;
          st_acc_ld = 1'b1;
        end
        default: begin
          if (ch >= CH_ONE && ch <= CH_NINE) begin
            st_mode   = M_DEC;
            st_acc_ld = 1'b1;
            st_acc    = {60'd0, ch[3:0]};
          end else begin
            st_emit = 1'b1;
            st_byte = ch;
          end
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    has0     = 1'b0;
    rec      = '{two: 1'b0, k0: K_BADCHAR, v0: '0, b0: '0, k1: K_BADCHAR, b1: '0};
    unique case (mode_r)
      M_ZERO: begin
        if (!eoi && ch == CH_X) begin
          acc_nxt  = '0;
          mode_nxt = M_HEX;
        end else if (!eoi && is_oct) begin
          acc_nxt  = {61'd0, ch[2:0]};
          mode_nxt = M_OCT;
        end else if (!eoi && is_89) begin
          has0     = 1'b1;
          rec.k0   = K_BADCHAR;
          rec.b0   = ch;
          mode_nxt = M_IDLE;
        end else begin
          // lone zero, then rescan
          has0     = 1'b1;
          rec.k0   = K_INTEGER;
          rec.two  = st_emit;
          rec.k1   = st_kind;
          rec.b1   = st_byte;
          mode_nxt = st_mode;
          acc_nxt  = st_acc_ld ? st_acc : '0;
        end
      end
      M_DEC, M_OCT, M_HEX: begin
        if (!eoi && mode_r == M_DEC && is_dig) begin
          acc_nxt = acc_dec;
        end else if (!eoi && mode_r == M_OCT && is_oct) begin
          acc_nxt = acc_oct;
        end else if (!eoi && mode_r == M_HEX && is_hex) begin
          acc_nxt = acc_hex;
        end else if (!eoi && mode_r == M_OCT && is_89) begin
          has0     = 1'b1;
          rec.k0   = K_BADCHAR;
          rec.b0   = ch;
          mode_nxt = M_IDLE;
        end else begin
          // number ends, byte rescanned
          has0     = 1'b1;
          rec.k0   = K_INTEGER;
          rec.v0   = acc_r;
          rec.two  = st_emit;
          rec.k1   = st_kind;
          rec.b1   = st_byte;
          mode_nxt = st_mode;
          if (st_acc_ld) acc_nxt = st_acc;
        end
      end
      M_STR: begin
        has0 = 1'b1;
        if (eoi) begin
          rec.k0   = K_UNTERM;
          mode_nxt = M_IDLE;
        end else if (ch == CH_QUOTE) begin
          rec.k0   = K_STREND;
          mode_nxt = M_IDLE;
        end else if (ch == CH_BSLASH) begin
          has0     = 1'b0;
          mode_nxt = M_ESC;
        end else begin
          rec.k0 = K_STRBYTE;
          rec.b0 = ch;
        end
      end
      M_ESC: begin
        has0     = 1'b1;
        mode_nxt = M_STR;
        rec.k0   = K_STRBYTE;
        if (eoi) begin
          rec.k0   = K_UNTERM;
          mode_nxt = M_IDLE;
        end else if (ch == CH_QUOTE) begin
          rec.b0 = CH_QUOTE;
        end else if (ch == CH_N) begin
          rec.b0 = CH_LF;
        end else if (ch == CH_R) begin
          rec.b0 = CH_CR;
        end else if (ch == CH_T) begin
          rec.b0 = CH_TAB;
        end else begin
          rec.k0   = K_BADESC;
          rec.b0   = ch;
          mode_nxt = M_IDLE;
        end
      end
      default: begin
        has0     = st_emit;
        rec.k0   = st_kind;
        rec.b0   = st_byte;
        mode_nxt = st_mode;
        if (st_acc_ld) acc_nxt = st_acc;
      end
    endcase
  end

  assign push     = accept && has0;
  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== rtl/jts_queue.sv =====
// ----------------------------------------------------------------------------
// jts_queue
// short first-in first-out queue of result records between scanner and emitter
// ----------------------------------------------------------------------------
module jts_queue import jts_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  rec_t   push_rec,
  input  logic   pop,
  output rec_t   head_rec,
  output qstat_t stat
);

  rec_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == QCW'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign head_rec   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/jts_back.sv =====
// ----------------------------------------------------------------------------
// jts_back
// emitter: splits each record into one or two tokens on the output register
// ----------------------------------------------------------------------------
module jts_back import jts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rec_t        head_rec,
  input  qstat_t      q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [63:0] out_int_value,
  output logic [7:0]  out_string_byte,
  output logic        out_last
);

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [63:0] int_r, int_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        sec_pend_r, sec_pend_nxt;
  kind_t       sec_kind_r, sec_kind_nxt;
  logic [7:0]  sec_byte_r, sec_byte_nxt;
  logic        load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !sec_pend_r && !q_stat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    int_nxt       = int_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    sec_pend_nxt  = sec_pend_r;
    sec_kind_nxt  = sec_kind_r;
    sec_byte_nxt  = sec_byte_r;
    if (load) begin
      priority if (sec_pend_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = sec_kind_r;
        int_nxt       = '0;
        byte_nxt      = sec_byte_r;
        last_nxt      = 1'b1;
        sec_pend_nxt  = 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = head_rec.k0;
        int_nxt       = head_rec.v0;
        byte_nxt      = head_rec.b0;
        last_nxt      = !head_rec.two;
        sec_pend_nxt  = head_rec.two;
        sec_kind_nxt  = head_rec.k1;
        sec_byte_nxt  = head_rec.b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_pend_r  <= sec_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    int_r      <= int_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    sec_kind_r <= sec_kind_nxt;
    sec_byte_r <= sec_byte_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = 4'(kind_r);
  assign out_int_value   = int_r;
  assign out_string_byte = byte_r;
  assign out_last        = last_r;

endmodule
